@@ rtl/dlse_pkg.sv @@
package dlse_pkg;

  // standard opcodes of the line program
  localparam logic [7:0] OP_COPY      = 8'd1;
  localparam logic [7:0] OP_ADV_PC    = 8'd2;
  localparam logic [7:0] OP_ADV_LINE  = 8'd3;
  localparam logic [7:0] OP_CONST_ADD = 8'd8;

  // header values: opcode base 13, line base -1, line range 4
  localparam logic [7:0] OPC_BASE       = 8'd13;
  localparam logic [8:0] SPECIAL_MAX    = 9'd242;
  localparam logic [8:0] CONST_ADJ      = 9'd227;
  localparam logic [6:0] CONST_ADDR_LIM = 7'd120;

  // divide by 59 through a reciprocal: q = (a * DIV59_MUL) >> DIV59_SHIFT, exact for a < 2^31
  localparam logic [31:0] DIV59_MUL   = 32'd2329473788;
  localparam int          DIV59_SHIFT = 37;

  // depth of the queue between front and back
  localparam int FIFO_DEPTH = 2;

  // how the row is closed
  typedef enum logic [1:0] {
    FIN_ONE,    // copy or special opcode, one byte
    FIN_CONST,  // constant pc step then special opcode
    FIN_BIG     // pc advance with leb operand, then tail byte
  } fin_kind_e;

  // classified step, everything the back end needs
  typedef struct packed {
    logic        line_adv;
    logic [31:0] line_val;
    logic        addr_neg;
    logic [31:0] addr_val;
    fin_kind_e   kind;
    logic [7:0]  fin_byte;
    logic [31:0] big_val;
  } step_desc_t;

endpackage

@@ rtl/dlse_front.sv @@
module dlse_front import dlse_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] line_delta_i,
  input  logic [31:0] addr_delta_i,
  output logic        desc_valid_o,
  input  logic        desc_ready_i,
  output step_desc_t  desc_o
);

  logic        s1_v_q;
  logic        s1_line_adv_q;
  logic [31:0] s1_lu_q;
  logic [31:0] s1_au_q;
  logic [1:0]  s1_lp_q;
  logic [62:0] s1_prod_q;

  logic        in_win;
  logic [30:0] a_in;
  logic [62:0] prod_d;

  // line delta window and reciprocal product for the mod 59 split
  assign in_win     = (line_delta_i == 32'hFFFF_FFFF) || (line_delta_i <= 32'd2);
  assign a_in       = addr_delta_i[31] ? 31'd0 : addr_delta_i[30:0];
  assign prod_d     = 63'(a_in) * 63'(DIV59_MUL);
  assign in_ready_o = !s1_v_q || desc_ready_i;

  // input register stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_line_adv_q <= !in_win;
      s1_lu_q       <= line_delta_i;
      s1_au_q       <= addr_delta_i;
      s1_lp_q       <= in_win ? (line_delta_i[1:0] + 2'd1) : 2'd1;
      s1_prod_q     <= prod_d;
    end
  end

  logic [30:0] a;
  logic        a_short;
  logic [8:0]  t9;
  logic        is_copy;
  logic        is_special;
  logic        is_const;
  logic [25:0] q;
  logic [31:0] p;
  logic [5:0]  r;
  logic [7:0]  tail;

  // classification of the remaining deltas
  assign a          = s1_au_q[31] ? 31'd0 : s1_au_q[30:0];
  assign a_short    = (a[30:7] == '0);
  assign t9         = {a[6:0], 2'b00} + 9'(s1_lp_q);
  assign is_copy    = (a == '0) && (s1_lp_q == 2'd1);
  assign is_special = a_short && (t9 <= SPECIAL_MAX);
  assign is_const   = a_short && (a[6:0] < CONST_ADDR_LIM);

  // split a into 59*q plus remainder, remainder fits in six bits
  assign q    = s1_prod_q[62:DIV59_SHIFT];
  assign p    = {q, 6'b0} - 32'({q, 2'b00}) - 32'(q);
  assign r    = a[5:0] - p[5:0];
  assign tail = (s1_lp_q == 2'd1) ? OP_COPY
              : (8'(s1_lp_q) + {r, 2'b00} + OPC_BASE);

  // descriptor toward the queue
  always_comb begin
    desc_o          = '0;
    desc_o.line_adv = s1_line_adv_q;
    desc_o.line_val = s1_lu_q;
    desc_o.addr_neg = s1_au_q[31];
    desc_o.addr_val = s1_au_q;
    desc_o.big_val  = (s1_lp_q == 2'd1) ? {1'b0, a} : p;
    if (is_copy) begin
      desc_o.kind     = FIN_ONE;
      desc_o.fin_byte = OP_COPY;
    end else if (is_special) begin
      desc_o.kind     = FIN_ONE;
      desc_o.fin_byte = t9[7:0] + OPC_BASE;
    end else if (is_const) begin
      desc_o.kind     = FIN_CONST;
      desc_o.fin_byte = 8'(t9 - CONST_ADJ);
    end else begin
      desc_o.kind     = FIN_BIG;
      desc_o.fin_byte = tail;
    end
  end

  assign desc_valid_o = s1_v_q;

endmodule

@@ rtl/dlse_fifo.sv @@
module dlse_fifo import dlse_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_valid_i,
  output logic       push_ready_o,
  input  step_desc_t push_data_i,
  output logic       pop_valid_o,
  input  logic       pop_ready_i,
  output step_desc_t pop_data_o
);

  localparam int PtrW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CntW = $clog2(FIFO_DEPTH + 1);

  step_desc_t      mem_q [FIFO_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            push, pop;

  assign push_ready_o = (cnt_q != CntW'(FIFO_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

@@ rtl/dlse_back.sv @@
module dlse_back import dlse_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       head_valid_i,
  input  step_desc_t head_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       out_last_o
);

  typedef enum logic [3:0] {
    ST_START,
    ST_LINE_OP,
    ST_LINE_SLEB,
    ST_ADDR_OP,
    ST_ADDR_SLEB,
    ST_FIN_OP,
    ST_FIN2,
    ST_BIG_SLEB,
    ST_TAIL
  } state_e;

  state_e      state_q, state_d, cur;
  logic [31:0] v_q, v_d;
  logic        out_v_q;
  logic [7:0]  byte_q;
  logic        last_q;

  logic        adv, fire;
  logic [7:0]  byte_d;
  logic        last_d;

  // leb128 digit of the working value
  logic [31:0] vn;
  logic        sleb_done;
  assign vn        = 32'($signed(v_q) >>> 7);
  assign sleb_done = v_q[31] ? ((&vn) && v_q[6]) : ((vn == '0) && !v_q[6]);

  assign adv  = !out_v_q || out_ready_i;
  assign fire = adv && head_valid_i;

  // first step of a new word is taken straight from the queue head
  always_comb begin
    cur = state_q;
    if (state_q == ST_START) begin
      if (head_i.line_adv) begin
        cur = ST_LINE_OP;
      end else if (head_i.addr_neg) begin
        cur = ST_ADDR_OP;
      end else begin
        cur = ST_FIN_OP;
      end
    end
  end

  // byte selection and next step
  always_comb begin
    state_d = cur;
    v_d     = v_q;
    byte_d  = '0;
    last_d  = 1'b0;
    unique case (cur)
      ST_LINE_OP: begin
        byte_d  = OP_ADV_LINE;
        v_d     = head_i.line_val;
        state_d = ST_LINE_SLEB;
      end
      ST_LINE_SLEB: begin
        byte_d = {!sleb_done, v_q[6:0]};
        v_d    = vn;
        if (sleb_done) begin
          state_d = head_i.addr_neg ? ST_ADDR_OP : ST_FIN_OP;
        end
      end
      ST_ADDR_OP: begin
        byte_d  = OP_ADV_PC;
        v_d     = head_i.addr_val;
        state_d = ST_ADDR_SLEB;
      end
      ST_ADDR_SLEB: begin
        byte_d = {!sleb_done, v_q[6:0]};
        v_d    = vn;
        if (sleb_done) begin
          state_d = ST_FIN_OP;
        end
      end
      ST_FIN_OP: begin
        case (head_i.kind)
          FIN_CONST: begin
            byte_d  = OP_CONST_ADD;
            state_d = ST_FIN2;
          end
          FIN_BIG: begin
            byte_d  = OP_ADV_PC;
            v_d     = head_i.big_val;
            state_d = ST_BIG_SLEB;
          end
          default: begin
            byte_d  = head_i.fin_byte;
            last_d  = 1'b1;
            state_d = ST_START;
          end
        endcase
      end
      ST_FIN2: begin
        byte_d  = head_i.fin_byte;
        last_d  = 1'b1;
        state_d = ST_START;
      end
      ST_BIG_SLEB: begin
        byte_d = {!sleb_done, v_q[6:0]};
        v_d    = vn;
        if (sleb_done) begin
          state_d = ST_TAIL;
        end
      end
      ST_TAIL: begin
        byte_d  = head_i.fin_byte;
        last_d  = 1'b1;
        state_d = ST_START;
      end
      default: begin
        state_d = ST_START;
      end
    endcase
  end

  assign pop_o = fire && last_d;

  // sequencer state and output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_START;
      v_q     <= '0;
      out_v_q <= 1'b0;
      byte_q  <= '0;
      last_q  <= 1'b0;
    end else if (fire) begin
      state_q <= state_d;
      v_q     <= v_d;
      out_v_q <= 1'b1;
      byte_q  <= byte_d;
      last_q  <= last_d;
    end else if (adv) begin
      out_v_q <= 1'b0;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_byte_o  = byte_q;
  assign out_last_o  = last_q;

endmodule

@@ rtl/dwarf_line_step_encoder.sv @@
// Line-table step encoder: turns one (line delta, address delta) pair into
// the bytes of a line-number program row (line base -1, line range 4,
// opcode base 13).
// Input stream: s_axis_tdata carries line_delta in bits 31:0 and
// addr_delta in bits 63:32, both signed. A word is taken when tvalid and
// tready are high at a rising edge.
// Output stream: one program byte per word on m_axis_tdata, m_axis_tlast
// marks the final byte of the pair (1 to 13 bytes per pair).
// On the way out, the first byte of a pair passes the input register, the
// queue and the output register.
// Throughput: the byte sequencer emits one byte per cycle while the receiver
// is ready; one-byte rows sustain one pair per cycle.
// A two-entry queue between the classifier and the sequencer lets the input
// keep flowing while a long row is emitted, and the input stalls once the
// queue is full.
// When the receiver drops tready the output word holds, the sequencer stops
// and back pressure reaches the input through the queue; nothing is lost.
// Reset (rst_ni low, asynchronous) empties all stages and the queue.
module dwarf_line_step_encoder import dlse_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [31:0] line_delta, [63:32] addr_delta
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic        m_axis_tlast    // last_byte
);

  logic       desc_valid, desc_ready;
  step_desc_t desc;
  logic       head_valid, pop;
  step_desc_t head;

  // classifier
  dlse_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .line_delta_i (s_axis_tdata[31:0]),
    .addr_delta_i (s_axis_tdata[63:32]),
    .desc_valid_o (desc_valid),
    .desc_ready_i (desc_ready),
    .desc_o       (desc)
  );

  // decoupling queue
  dlse_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (desc_valid),
    .push_ready_o (desc_ready),
    .push_data_i  (desc),
    .pop_valid_o  (head_valid),
    .pop_ready_i  (pop),
    .pop_data_o   (head)
  );

  // byte sequencer
  dlse_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_byte_o   (m_axis_tdata),
    .out_last_o   (m_axis_tlast)
  );

endmodule
